### rtl/ldfp_pkg.sv
// Package for the downlink frame parser: status and byte-role codes,
// plus the small layout helpers shared by the parser logic.
// No dependencies.
package ldfp_pkg;

    typedef enum logic [1:0] {
        STATUS_CONTINUE = 2'd0,
        STATUS_ACCEPT   = 2'd1,
        STATUS_REJECT   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ROLE_HEADER     = 4'd0,
        ROLE_NONCE      = 4'd1,
        ROLE_NETID      = 4'd2,
        ROLE_DEVADDR    = 4'd3,
        ROLE_DLSETTINGS = 4'd4,
        ROLE_RXDELAY    = 4'd5,
        ROLE_CFLIST     = 4'd6,
        ROLE_FCTRL      = 4'd7,
        ROLE_FCNT       = 4'd8,
        ROLE_FOPTS      = 4'd9,
        ROLE_PORT       = 4'd10,
        ROLE_PAYLOAD    = 4'd11,
        ROLE_MIC        = 4'd12,
        ROLE_UNPARSED   = 4'd13
    } role_t;

    localparam logic [2:0] TYPE_JOIN_ACCEPT = 3'd1;
    localparam logic [2:0] TYPE_DATA_UNCONF = 3'd3;
    localparam logic [2:0] TYPE_DATA_CONF   = 3'd5;

    localparam logic [8:0] JOIN_LEN_SHORT = 9'd17;
    localparam logic [8:0] JOIN_LEN_LONG  = 9'd33;
    localparam logic [7:0] CFLIST_LEN     = 8'd16;

    // ORs one byte into a little-endian accumulator at byte lane k.
    function automatic logic [31:0] put_le(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [1:0] k);
        logic [31:0] lane;
        lane = {24'd0, b} << {k, 3'b000};
        return acc | lane;
    endfunction

    function automatic role_t join_role(input logic [8:0] p, input logic [8:0] len);
        role_t r;
        if (p <= 9'd3)       r = ROLE_NONCE;
        else if (p <= 9'd6)  r = ROLE_NETID;
        else if (p <= 9'd10) r = ROLE_DEVADDR;
        else if (p == 9'd11) r = ROLE_DLSETTINGS;
        else if (p == 9'd12) r = ROLE_RXDELAY;
        else if (len > JOIN_LEN_SHORT) begin
            if (p <= 9'd28)      r = ROLE_CFLIST;
            else if (p <= 9'd32) r = ROLE_MIC;
            else                 r = ROLE_UNPARSED;
        end
        else if (p <= 9'd16) r = ROLE_MIC;
        else                 r = ROLE_UNPARSED;
        return r;
    endfunction

    function automatic role_t data_role(input logic [8:0] p, input logic [8:0] len,
                                        input logic [3:0] opts);
        logic [8:0] base;
        role_t      r;
        base = 9'd8 + {5'd0, opts};
        if (p <= 9'd4)      r = ROLE_DEVADDR;
        else if (p == 9'd5) r = ROLE_FCTRL;
        else if (p <= 9'd7) r = ROLE_FCNT;
        else if (p < base)  r = ROLE_FOPTS;
        else if (len > base + 9'd4) begin
            if (p == base)             r = ROLE_PORT;
            else if (p < len - 9'd4)   r = ROLE_PAYLOAD;
            else                       r = ROLE_MIC;
        end
        else if (p < base + 9'd4) r = ROLE_MIC;
        else                      r = ROLE_UNPARSED;
        return r;
    endfunction

endpackage

### rtl/lorawan_downlink_frame_parser.sv
// Downlink MAC frame parser: tags each received byte with its role and
// reports the decoded frame fields at the last byte. Depends on ldfp_pkg.
//
//   channel   handshake                 payload
//   byte      byte_valid / byte_stall   frame_byte, frame_length, first_of_frame
//   result    result_valid / result_stall  status, frame_type, byte_role, fields
//
// Each accepted byte produces exactly one result in the next cycle; a byte can be
// taken in every cycle that byte_stall is low. The per-byte decode sits between
// the frame state registers and the result register. Reset clears the frame
// position, length, type and reject flag and the result valid flag. The byte
// channel stalls only while a result is held and the result side stalls.
module lorawan_downlink_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  frame_byte,
    input  logic [7:0]  frame_length,
    input  logic        first_of_frame,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [2:0]  frame_type,
    output logic [3:0]  byte_role,
    output logic [31:0] device_address,
    output logic [23:0] nonce_or_counter,
    output logic [23:0] network_id,
    output logic [7:0]  control_bits,
    output logic [7:0]  receive_delay,
    output logic        body_present,
    output logic [7:0]  port_number,
    output logic [7:0]  body_length,
    output logic [31:0] integrity_code
);
    import ldfp_pkg::*;

    // Frame state.
    logic [7:0]  position_reg,  position_next;
    logic [7:0]  length_reg,    length_next;
    logic [2:0]  type_reg,      type_next;
    logic        reject_reg,    reject_next;
    logic [7:0]  control_reg,   control_next;
    logic [31:0] address_reg,   address_next;
    logic [23:0] nonce_reg,     nonce_next;
    logic [23:0] netid_reg,     netid_next;
    logic [7:0]  delay_reg,     delay_next;
    logic [7:0]  port_reg,      port_next;
    logic [31:0] code_reg,      code_next;

    // Result register.
    logic        valid_reg;
    status_t     status_reg,    status_next;
    logic [2:0]  ftype_reg;
    role_t       role_reg,      role_next;
    logic [31:0] addr_out_reg,  addr_out_next;
    logic [23:0] nonce_out_reg, nonce_out_next;
    logic [23:0] netid_out_reg, netid_out_next;
    logic [7:0]  ctrl_out_reg,  ctrl_out_next;
    logic [7:0]  delay_out_reg, delay_out_next;
    logic        body_out_reg,  body_out_next;
    logic [7:0]  port_out_reg,  port_out_next;
    logic [7:0]  blen_out_reg,  blen_out_next;
    logic [31:0] code_out_reg,  code_out_next;

    logic accept;

    assign byte_stall = valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        logic       stray;
        logic       last;
        logic       ok;
        logic       body;
        logic [7:0] blen;
        logic [7:0] delay;
        logic [8:0] p;
        logic [8:0] len;
        logic [8:0] need;
        logic [3:0] opts;
        logic [7:0] flen;

        stray = 1'b0;
        last  = 1'b0;
        need  = 9'd0;
        ok    = 1'b0;
        body  = 1'b0;
        blen  = 8'd0;
        delay = 8'd0;
        flen  = (frame_length == 8'd0) ? 8'd1 : frame_length;

        position_next = position_reg;
        length_next   = length_reg;
        type_next     = type_reg;
        reject_next   = reject_reg;
        control_next  = control_reg;
        address_next  = address_reg;
        nonce_next    = nonce_reg;
        netid_next    = netid_reg;
        delay_next    = delay_reg;
        port_next     = port_reg;
        code_next     = code_reg;

        status_next    = STATUS_CONTINUE;
        role_next      = ROLE_UNPARSED;
        addr_out_next  = '0;
        nonce_out_next = '0;
        netid_out_next = '0;
        ctrl_out_next  = '0;
        delay_out_next = '0;
        body_out_next  = 1'b0;
        port_out_next  = '0;
        blen_out_next  = '0;
        code_out_next  = '0;

        if (first_of_frame) begin
            // A header always opens a fresh frame, dropping any open one.
            position_next = 8'd0;
            length_next   = flen;
            type_next     = frame_byte[7:5];
            reject_next   = (frame_byte[4:0] != 5'd0) ||
                            !(frame_byte[7:5] == TYPE_JOIN_ACCEPT ||
                              frame_byte[7:5] == TYPE_DATA_UNCONF ||
                              frame_byte[7:5] == TYPE_DATA_CONF);
            control_next  = '0;
            address_next  = '0;
            nonce_next    = '0;
            netid_next    = '0;
            delay_next    = '0;
            port_next     = '0;
            code_next     = '0;
            role_next     = ROLE_HEADER;
        end
        else if (length_reg == 8'd0) begin
            stray = 1'b1;
        end

        p    = {1'b0, position_next};
        len  = {1'b0, length_next};
        opts = control_reg[3:0];

        if (!stray) begin
            code_next = {frame_byte, code_next[31:8]};
            if (!first_of_frame && !reject_reg) begin
                if (type_reg == TYPE_JOIN_ACCEPT) begin
                    role_next = join_role(p, len);
                    unique case (role_next)
                        ROLE_NONCE:
                            nonce_next = 24'(put_le({8'd0, nonce_reg}, frame_byte,
                                                    2'(p - 9'd1)));
                        ROLE_NETID:
                            netid_next = 24'(put_le({8'd0, netid_reg}, frame_byte,
                                                    2'(p - 9'd4)));
                        ROLE_DEVADDR:
                            address_next = put_le(address_reg, frame_byte, 2'(p - 9'd7));
                        ROLE_DLSETTINGS: control_next = frame_byte;
                        ROLE_RXDELAY:    delay_next   = frame_byte;
                        default: ;
                    endcase
                end
                else begin
                    role_next = data_role(p, len, opts);
                    unique case (role_next)
                        ROLE_DEVADDR:
                            address_next = put_le(address_reg, frame_byte, 2'(p - 9'd1));
                        ROLE_FCTRL: control_next = frame_byte;
                        ROLE_FCNT:
                            nonce_next = 24'(put_le({8'd0, nonce_reg}, frame_byte,
                                                    2'(p - 9'd6)));
                        ROLE_PORT:  port_next = frame_byte;
                        default: ;
                    endcase
                end
            end

            last = (p + 9'd1) >= len;
            if (last) begin
                // The end-of-frame checks see this byte's field updates.
                if (!reject_next) begin
                    if (type_next == TYPE_JOIN_ACCEPT) begin
                        ok    = (len == JOIN_LEN_SHORT) || (len == JOIN_LEN_LONG);
                        body  = len > JOIN_LEN_SHORT;
                        blen  = body ? CFLIST_LEN : 8'd0;
                        delay = (delay_next == 8'd0) ? 8'd1 : delay_next;
                    end
                    else begin
                        need  = 9'd12 + {5'd0, control_next[3:0]};
                        body  = len > need;
                        blen  = body ? 8'(len - need - 9'd1) : 8'd0;
                        ok    = (len >= need) &&
                                !(body && control_next[3:0] != 4'd0 && port_next == 8'd0);
                        netid_next = '0;
                    end
                end
                status_next = ok ? STATUS_ACCEPT : STATUS_REJECT;
                if (ok) begin
                    addr_out_next  = address_next;
                    nonce_out_next = nonce_next;
                    netid_out_next = netid_next;
                    ctrl_out_next  = control_next;
                    delay_out_next = delay;
                    body_out_next  = body;
                    port_out_next  = body ? port_next : 8'd0;
                    blen_out_next  = blen;
                    code_out_next  = code_next;
                end
                length_next   = 8'd0;
                position_next = 8'd0;
            end
            else begin
                position_next = 8'(p + 9'd1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg    <= 1'b0;
            position_reg <= '0;
            length_reg   <= '0;
            type_reg     <= '0;
            reject_reg   <= 1'b0;
        end
        else begin
            if (accept) begin
                valid_reg    <= 1'b1;
                position_reg <= position_next;
                length_reg   <= length_next;
                type_reg     <= type_next;
                reject_reg   <= reject_next;
            end
            else if (!result_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Field accumulators and result payload.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            control_reg   <= control_next;
            address_reg   <= address_next;
            nonce_reg     <= nonce_next;
            netid_reg     <= netid_next;
            delay_reg     <= delay_next;
            port_reg      <= port_next;
            code_reg      <= code_next;
            status_reg    <= status_next;
            ftype_reg     <= type_next;
            role_reg      <= role_next;
            addr_out_reg  <= addr_out_next;
            nonce_out_reg <= nonce_out_next;
            netid_out_reg <= netid_out_next;
            ctrl_out_reg  <= ctrl_out_next;
            delay_out_reg <= delay_out_next;
            body_out_reg  <= body_out_next;
            port_out_reg  <= port_out_next;
            blen_out_reg  <= blen_out_next;
            code_out_reg  <= code_out_next;
        end
    end

    assign result_valid     = valid_reg;
    assign status           = status_reg;
    assign frame_type       = ftype_reg;
    assign byte_role        = role_reg;
    assign device_address   = addr_out_reg;
    assign nonce_or_counter = nonce_out_reg;
    assign network_id       = netid_out_reg;
    assign control_bits     = ctrl_out_reg;
    assign receive_delay    = delay_out_reg;
    assign body_present     = body_out_reg;
    assign port_number      = port_out_reg;
    assign body_length      = blen_out_reg;
    assign integrity_code   = code_out_reg;

    // Every accepted byte leaves a result behind it.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted byte produced no result");

    // With no frame open the byte position is always back at zero.
    a_idle_position: assert property (@(posedge clk) disable iff (!rst_n)
        (length_reg == 8'd0) |-> (position_reg == 8'd0))
        else $error("byte position nonzero with no open frame");

    // Decoded fields only appear on an accepted frame.
    a_fields_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != STATUS_ACCEPT) |->
            (addr_out_reg == 32'd0 && code_out_reg == 32'd0 && body_out_reg == 1'b0))
        else $error("decoded fields leaked on a non-accepted result");

    // The header byte of a frame is always reported with the header role.
    a_header_role: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_of_frame) |=> (role_reg == ROLE_HEADER))
        else $error("header byte not tagged as header");

endmodule
